// ----- src/sik_pkg.sv -----
// sik_pkg: shared types, constants and helper functions for the scara
// inverse kinematics block (cordic stage record, state encoding, rounding)
// no dependencies
package sik_pkg;

	// cordic datapath widths: operands normalized to 2^40, angle in degrees q24
	localparam int DW = 44;
	localparam int ZW = 35;
	localparam int ROOT_IW = 48;
	localparam int ROOT_OW = 24;

	localparam logic signed [ZW-1:0] ANG_LIM = 35'sd3019898880;
	localparam logic signed [DW-1:0] NORM_HI = 44'sh100_0000_0000;
	localparam logic signed [DW-1:0] NORM_LO = -NORM_HI;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_REACH = 2'd0;
	localparam logic [1:0] REG_MIN_REACH = 2'd1;
	localparam logic [1:0] REG_ELBOW_SEL = 2'd2;

	typedef struct packed {
		logic                 vld;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_R2,
		ST_CHECK,
		ST_ROOT,
		ST_RWAIT,
		ST_NORM,
		ST_FEEDA,
		ST_FEEDB,
		ST_WAIT,
		ST_ANG,
		ST_FIN
	} state_t;

	// elementary angle of micro-rotation i in degrees q24
	function automatic longint elem_angle(input int i);
		longint r;
		begin
			case (i)
				0: r = 64'd754974720;
				1: r = 64'd445687602;
				2: r = 64'd235489089;
				3: r = 64'd119537938;
				4: r = 64'd60000934;
				5: r = 64'd30029717;
				6: r = 64'd15018523;
				7: r = 64'd7509720;
				8: r = 64'd3754917;
				9: r = 64'd1877466;
				10: r = 64'd938734;
				11: r = 64'd469367;
				12: r = 64'd234684;
				13: r = 64'd117342;
				default: r = (64'd961263669 + (64'd1 << (i - 1))) >> i;
			endcase
			return r;
		end
	endfunction

	// magnitude reached the normalization threshold
	function automatic logic is_big(input logic signed [DW-1:0] v);
		return (v >= NORM_HI) || (v <= NORM_LO);
	endfunction

	// left half-plane pre-rotation by 180 degrees
	function automatic cordic_t prerot(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		cordic_t c;
		begin
			c.vld = 1'b1;
			if (b[DW-1]) begin
				c.x = -b;
				c.y = -a;
				c.z = a[DW-1] ? -ANG_LIM : ANG_LIM;
			end else begin
				c.x = b;
				c.y = a;
				c.z = '0;
			end
			return c;
		end
	endfunction

	function automatic logic signed [ZW-1:0] clamp_ang(input logic signed [ZW-1:0] z);
		logic signed [ZW-1:0] r;
		begin
			r = z;
			if (z > ANG_LIM) r = ANG_LIM;
			if (z < -ANG_LIM) r = -ANG_LIM;
			return r;
		end
	endfunction

	// doubled angle, optionally negated, rounded half away from zero, wrapped
	function automatic logic signed [8:0] joint_deg(input logic signed [ZW-1:0] z,
			input logic neg);
		logic signed [ZW+1:0] v;
		logic [ZW+1:0] mag;
		logic [ZW+2:0] rnd;
		logic [ZW-22:0] qm;
		logic signed [ZW-21:0] q;
		begin
			v = (ZW+2)'(z) * 37'sd2;
			if (neg) v = -v;
			mag = v[ZW+1] ? (ZW+2)'(-v) : (ZW+2)'(v);
			rnd = (ZW+3)'(mag) + (ZW+3)'(38'd8388608);
			qm = rnd[ZW+2:24];
			q = v[ZW+1] ? -signed'({1'b0, qm}) : signed'({1'b0, qm});
			if (q > 14'sd180) q = q - 14'sd360;
			if (q < -14'sd180) q = q + 14'sd360;
			return q[8:0];
		end
	endfunction

endpackage

// ----- src/sik_isqrt.sv -----
// sik_isqrt: bit-pair integer square root, one result bit per cycle
// depends on sik_pkg
module sik_isqrt import sik_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ROOT_IW-1:0] din,
	output logic               busy,
	output logic [ROOT_OW-1:0] root
);

	logic               busy_q;
	logic [ROOT_IW-1:0] v_q;
	logic [ROOT_IW-1:0] r_q;
	logic [ROOT_IW-1:0] bit_q;
	logic [ROOT_IW:0]   trial;

	assign trial = {1'b0, r_q} + {1'b0, bit_q};

	// run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	// remainder, partial root and current bit pair
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= din;
			r_q <= '0;
			bit_q <= ROOT_IW'(1) << (ROOT_IW - 2);
		end else if (busy_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q <= v_q - trial[ROOT_IW-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[ROOT_OW-1:0];

endmodule

// ----- src/sik_cordic_cell.sv -----
// sik_cordic_cell: one vectoring micro-rotation with a fixed shift, registered
// depends on sik_pkg
module sik_cordic_cell import sik_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cordic_t din,
	output cordic_t dout
);

	localparam logic signed [ZW-1:0] ANG = ZW'(elem_angle(STEP));

	cordic_t nxt;
	cordic_t q_q;
	logic    vld_q;

	// rotate toward the positive x axis
	always_comb begin
		nxt = din;
		if (!din.y[DW-1] && (din.y != '0)) begin
			nxt.x = din.x + (din.y >>> STEP);
			nxt.y = din.y - (din.x >>> STEP);
			nxt.z = din.z + ANG;
		end else begin
			nxt.x = din.x - (din.y >>> STEP);
			nxt.y = din.y + (din.x >>> STEP);
			nxt.z = din.z - ANG;
		end
	end

	// valid bit travels with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= nxt;
	end

	always_comb begin
		dout = q_q;
		dout.vld = vld_q;
	end

endmodule

// ----- src/scara_inverse_kinematics.sv -----
// scara_inverse_kinematics: top level, sequencer plus a chain of cordic cells
// depends on sik_pkg, sik_isqrt, sik_cordic_cell
//
// Usage: one target pose enters per item transaction (x_pos, y_pos, z_height,
// tool_yaw) and one joint set leaves per result transaction. Both channels
// are valid/ready. The block works on one pose at a time; item_ready is high
// only while the sequencer is idle.
// Steps per pose: squaring and range check, the square root (skipped when the
// radicand is not positive), operand normalization (one doubling per cycle,
// until both operand pairs are normalized), the two feed states, the chain
// of CORDIC_STEPS cells, then rounding and the output register. The sequencer
// then returns to idle, where it takes the next pose.
// A pose out of reach skips the root, the normalization and the chain.
// Both atan2 evaluations share the one chain; the second operand pair enters
// it in the cycle after the first.
// An output register holds the finished result; the next pose is taken while
// it waits. If the receiver stalls and a second result is ready, the
// sequencer waits in its last state until the register is free.
// Reset clears the held angles to zero, restores the reach registers and
// elbow branch to their defaults and empties the chain and output register.
// Configuration writes are taken at any edge with cfg_we high.
module scara_inverse_kinematics import sik_pkg::*; #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [8:0]        cfg_data,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic signed [9:0] x_pos,
	input  logic signed [9:0] y_pos,
	input  logic [7:0]        z_height,
	input  logic signed [8:0] tool_yaw,
	output logic              result_valid,
	input  logic              result_ready,
	output logic signed [8:0] shoulder_angle,
	output logic signed [8:0] elbow_angle,
	output logic signed [8:0] lift_travel,
	output logic signed [10:0] wrist_angle,
	output logic              in_reach
);

	state_t state_q, state_d;

	logic [8:0] max_q, min_q;
	logic       elbow_q;

	logic signed [9:0] x_q, y_q;
	logic [7:0]        zh_q;
	logic signed [8:0] yaw_q;
	logic [18:0]       xx_q, yy_q;
	logic [17:0]       mx2_q, mn2_q;
	logic              sel_q;
	logic [19:0]       r2_q;
	logic              ok_q;
	logic signed [41:0] rad_q;
	logic signed [DW-1:0] pa_a_q, pa_b_q, pb_a_q, pb_b_q;
	logic              zero_a_q, zero_b_q, got_a_q;
	logic signed [ZW-1:0] za_q, zb_q;
	logic signed [8:0] held_sh_q, held_el_q;

	logic              out_valid_q;
	logic signed [8:0] sh_out_q, el_out_q, lift_out_q;
	logic signed [10:0] wrist_out_q;
	logic              reach_out_q;

	logic signed [19:0] xsq, ysq;
	logic signed [20:0] r2s, p1, p2;
	logic signed [19:0] x300, y300;
	logic              rad_pos;
	logic              done_a, done_b;
	logic              sq_start, sq_busy;
	logic [ROOT_OW-1:0] sq_root;
	logic signed [DW-1:0] s_ext;
	logic              item_acc, out_load;
	cordic_t           feed;
	cordic_t           link [CORDIC_STEPS+1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 9'd325;
			min_q <= 9'd25;
			elbow_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_REACH: max_q <= cfg_data;
				REG_MIN_REACH: min_q <= cfg_data;
				REG_ELBOW_SEL: elbow_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// combinational helpers for the datapath
	assign xsq = x_pos * x_pos;
	assign ysq = y_pos * y_pos;
	assign r2s = signed'({1'b0, r2_q});
	assign p1 = r2s - 21'sd625;
	assign p2 = 21'sd105625 - r2s;
	assign x300 = x_q * 20'sd300;
	assign y300 = y_q * 20'sd300;
	assign rad_pos = !rad_q[41] && (rad_q != '0);
	assign done_a = is_big(pa_a_q) || is_big(pa_b_q) || ((pa_a_q == '0) && (pa_b_q == '0));
	assign done_b = is_big(pb_a_q) || is_big(pb_b_q) || ((pb_a_q == '0) && (pb_b_q == '0));
	assign s_ext = signed'(DW'(sq_root));
	assign item_acc = item_valid && item_ready;

	// square root unit
	sik_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.din    ({rad_q[31:0], 16'h0000}),
		.busy   (sq_busy),
		.root   (sq_root)
	);

	// cordic cell chain, one micro-rotation per cell
	assign link[0] = feed;
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		sik_cordic_cell #(.STEP(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (link[i]),
			.dout   (link[i+1])
		);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer outputs
	always_comb begin
		state_d = state_q;
		item_ready = 1'b0;
		sq_start = 1'b0;
		out_load = 1'b0;
		feed = prerot(pa_a_q, pa_b_q);
		feed.vld = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) state_d = ST_R2;
			end
			ST_R2: state_d = ST_CHECK;
			ST_CHECK: state_d = ST_ROOT;
			ST_ROOT: begin
				if (!ok_q) begin
					state_d = ST_ANG;
				end else if (rad_pos) begin
					sq_start = 1'b1;
					state_d = ST_RWAIT;
				end else begin
					state_d = ST_NORM;
				end
			end
			ST_RWAIT: if (!sq_busy) state_d = ST_NORM;
			ST_NORM: if (done_a && done_b) state_d = ST_FEEDA;
			ST_FEEDA: begin
				feed = prerot(pa_a_q, pa_b_q);
				state_d = ST_FEEDB;
			end
			ST_FEEDB: begin
				feed = prerot(pb_a_q, pb_b_q);
				state_d = ST_WAIT;
			end
			ST_WAIT: if (link[CORDIC_STEPS].vld && got_a_q) state_d = ST_ANG;
			ST_ANG: state_d = ST_FIN;
			ST_FIN: begin
				if (!out_valid_q || result_ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// operand datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					x_q <= x_pos;
					y_q <= y_pos;
					zh_q <= z_height;
					yaw_q <= tool_yaw;
					xx_q <= xsq[18:0];
					yy_q <= ysq[18:0];
					mx2_q <= 18'(max_q) * 18'(max_q);
					mn2_q <= 18'(min_q) * 18'(min_q);
					sel_q <= elbow_q;
				end
			end
			ST_R2: r2_q <= {1'b0, xx_q} + {1'b0, yy_q};
			ST_CHECK: begin
				ok_q <= (r2_q <= {2'b00, mx2_q}) && (r2_q > {2'b00, mn2_q});
				rad_q <= p1 * p2;
				pa_a_q <= DW'(y300) * 44'sd256;
				pa_b_q <= (DW'(r2s) - 44'sd8125 + DW'(x300)) * 44'sd256;
				pb_b_q <= (DW'(r2s) - 44'sd625) * 44'sd256;
				pb_a_q <= '0;
			end
			ST_RWAIT: begin
				if (!sq_busy) begin
					pa_a_q <= sel_q ? pa_a_q + s_ext : pa_a_q - s_ext;
					pb_a_q <= s_ext;
				end
			end
			ST_NORM: begin
				if (!done_a) begin
					pa_a_q <= pa_a_q <<< 1;
					pa_b_q <= pa_b_q <<< 1;
				end
				if (!done_b) begin
					pb_a_q <= pb_a_q <<< 1;
					pb_b_q <= pb_b_q <<< 1;
				end
			end
			ST_FEEDA: zero_a_q <= (pa_a_q == '0) && (pa_b_q == '0);
			ST_FEEDB: zero_b_q <= (pb_a_q == '0) && (pb_b_q == '0);
			ST_WAIT: begin
				if (link[CORDIC_STEPS].vld) begin
					if (!got_a_q) begin
						za_q <= zero_a_q ? '0 : clamp_ang(link[CORDIC_STEPS].z);
					end else begin
						zb_q <= zero_b_q ? '0 : clamp_ang(link[CORDIC_STEPS].z);
					end
				end
			end
			default: ;
		endcase
	end

	// chain result order and held joint angles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			got_a_q <= 1'b0;
			held_sh_q <= '0;
			held_el_q <= '0;
		end else begin
			if (state_q == ST_WAIT && link[CORDIC_STEPS].vld) got_a_q <= !got_a_q;
			if (state_q == ST_ANG && ok_q) begin
				held_sh_q <= joint_deg(za_q, 1'b0);
				held_el_q <= joint_deg(zb_q, sel_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sh_out_q <= held_sh_q;
			el_out_q <= held_el_q;
			lift_out_q <= signed'({1'b0, zh_q}) - 9'sd25;
			wrist_out_q <= 11'(yaw_q) - 11'(held_sh_q) - 11'(held_el_q);
			reach_out_q <= ok_q;
		end
	end

	assign result_valid = out_valid_q;
	assign shoulder_angle = sh_out_q;
	assign elbow_angle = el_out_q;
	assign lift_travel = lift_out_q;
	assign wrist_angle = wrist_out_q;
	assign in_reach = reach_out_q;

endmodule

// ----- src/sik_checker.sv -----
// sik_checker: port-level checks for scara_inverse_kinematics, with bind
// depends on scara_inverse_kinematics
module sik_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic signed [8:0] shoulder_angle,
	input logic signed [8:0] elbow_angle,
	input logic              in_reach
);

	// one pose in flight: an accepted transaction closes the input side
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while a pose is in flight");

	// stalled result transaction holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(shoulder_angle)
			&& $stable(elbow_angle) && $stable(in_reach))
		else $error("result changed while stalled");

	// wrapped joint angles stay within half a turn
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> shoulder_angle >= -9'sd180 && shoulder_angle <= 9'sd180
			&& elbow_angle >= -9'sd180 && elbow_angle <= 9'sd180)
		else $error("joint angle outside wrap range");

	// no result shows right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid out of reset");

endmodule

bind scara_inverse_kinematics sik_checker u_sik_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_ready     (item_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.shoulder_angle (shoulder_angle),
	.elbow_angle    (elbow_angle),
	.in_reach       (in_reach)
);

// ----- dv/scara_inverse_kinematics_test.sv -----
// scara_inverse_kinematics_test: self-checking bench for the scara inverse kinematics block
// drives random and corner poses, predicts joint sets in a local fixed-point model
// depends on sik_pkg and scara_inverse_kinematics
module scara_inverse_kinematics_test;
	import sik_pkg::*;

	typedef struct packed {
		logic signed [9:0] x;
		logic signed [9:0] y;
		logic [7:0]        z;
		logic signed [8:0] yaw;
	} pose_t;

	typedef struct packed {
		logic signed [8:0]  shoulder;
		logic signed [8:0]  elbow;
		logic signed [8:0]  lift;
		logic signed [10:0] wrist;
		logic               reach;
	} joints_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_MAX_REACH;
	logic [8:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic signed [9:0] x_pos = '0;
	logic signed [9:0] y_pos = '0;
	logic [7:0] z_height = '0;
	logic signed [8:0] tool_yaw = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [8:0] shoulder_angle, elbow_angle, lift_travel;
	logic signed [10:0] wrist_angle;
	logic in_reach;

	scara_inverse_kinematics DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state and configuration copy
	longint reach_hi = 325, reach_lo = 25;
	bit elbow_pos = 1'b1;
	longint last_shoulder = 0, last_elbow = 0;

	pose_t pending_poses[$];
	joints_t expected_joints[$];
	int mismatches = 0;
	int cycles = 0;
	bit idle_free = 1'b0;
	bit stimulus_done = 1'b0;

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint root_floor(longint v);
		longint r = 0, b = 64'sd1 <<< 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	// vectoring cordic atan2 in degrees q24
	function automatic longint atan2_q24(longint a, longint b);
		longint px, py, pz, lim, ma, mb, dx, dy, ea;
		lim = 64'sd180 <<< 24;
		if (a == 0 && b == 0) return 0;
		forever begin
			ma = a < 0 ? -a : a;
			mb = b < 0 ? -b : b;
			if ((ma > mb ? ma : mb) >= (64'sd1 <<< 40)) break;
			a = a * 2;
			b = b * 2;
		end
		if (b < 0) begin
			px = -b; py = -a; pz = (a >= 0) ? lim : -lim;
		end else begin
			px = b; py = a; pz = 0;
		end
		for (int i = 0; i < 24; i++) begin
			dx = shr_floor(py, i);
			dy = shr_floor(px, i);
			case (i)
				0: ea = 754974720;
				1: ea = 445687602;
				2: ea = 235489089;
				3: ea = 119537938;
				4: ea = 60000934;
				5: ea = 30029717;
				6: ea = 15018523;
				7: ea = 7509720;
				8: ea = 3754917;
				9: ea = 1877466;
				10: ea = 938734;
				11: ea = 469367;
				12: ea = 234684;
				13: ea = 117342;
				default: ea = (64'sd961263669 + (64'sd1 <<< (i - 1))) >>> i;
			endcase
			if (py > 0) begin
				px += dx; py -= dy; pz += ea;
			end else begin
				px -= dx; py += dy; pz -= ea;
			end
		end
		if (pz > lim) pz = lim;
		if (pz < -lim) pz = -lim;
		return pz;
	endfunction

	function automatic longint round_wrap(longint z, bit neg);
		longint v = 2 * z, q;
		if (neg) v = -v;
		if (v >= 0) q = (v + (64'sd1 <<< 23)) >>> 24;
		else q = -((-v + (64'sd1 <<< 23)) >>> 24);
		if (q > 180) q -= 360;
		if (q < -180) q += 360;
		return q;
	endfunction

	function automatic joints_t solve_pose(pose_t p);
		joints_t j;
		longint x, y, r2, rad, s, d1, d2, a1;
		x = p.x;
		y = p.y;
		r2 = x * x + y * y;
		j.reach = 1'b0;
		if (r2 <= reach_hi * reach_hi && r2 > reach_lo * reach_lo) begin
			rad = (r2 - 625) * (105625 - r2);
			s = rad > 0 ? root_floor(rad <<< 16) : 0;
			d1 = (r2 - 8125 + 300 * x) * 256;
			d2 = (r2 - 625) * 256;
			a1 = elbow_pos ? 300 * y * 256 + s : 300 * y * 256 - s;
			last_shoulder = round_wrap(atan2_q24(a1, d1), 1'b0);
			last_elbow = round_wrap(atan2_q24(s, d2), elbow_pos);
			j.reach = 1'b1;
		end
		j.shoulder = last_shoulder[8:0];
		j.elbow = last_elbow[8:0];
		j.lift = 9'(longint'(p.z) - 25);
		j.wrist = 11'(longint'(p.yaw) - last_shoulder - last_elbow);
		return j;
	endfunction

	// append a pose to the stimulus queue
	task automatic queue_pose(pose_t p);
		pending_poses.insert(pending_poses.size(), p);
	endtask

	// driver: present pending poses, idle at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				expected_joints.insert(expected_joints.size(),
					solve_pose({x_pos, y_pos, z_height, tool_yaw}));
				void'(pending_poses.pop_front());
			end
			if (!item_valid || item_ready) begin
				if (pending_poses.size() > 0 && (idle_free || $urandom_range(99) >= 29)) begin
					item_valid <= 1'b1;
					{x_pos, y_pos, z_height, tool_yaw} <= pending_poses[0];
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			result_ready <= idle_free || $urandom_range(99) >= 29;
			if (result_valid && result_ready) begin
				if (expected_joints.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result transaction");
				end else begin
					joints_t e;
					joints_t a;
					e = expected_joints.pop_front();
					a = {shoulder_angle, elbow_angle, lift_travel, wrist_angle, in_reach};
					if (a !== e) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp sh %0d el %0d lf %0d wr %0d ok %0b,",
								" got sh %0d el %0d lf %0d wr %0d ok %0b"},
								e.shoulder, e.elbow, e.lift, e.wrist, e.reach,
								a.shoulder, a.elbow, a.lift, a.wrist, a.reach);
					end
				end
			end
		end
	end

	task automatic drain();
		while (pending_poses.size() > 0 || item_valid || expected_joints.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [8:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MAX_REACH: reach_hi = val;
			REG_MIN_REACH: reach_lo = val;
			REG_ELBOW_SEL: elbow_pos = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic pose_t random_pose(bit wide);
		pose_t p;
		p.z = 8'($urandom_range(255));
		p.yaw = 9'($urandom);
		if (wide) begin
			p.x = 10'($urandom);
			p.y = 10'($urandom);
		end else begin
			p.x = $signed(10'($urandom_range(650))) - 10'sd325;
			p.y = $signed(10'($urandom_range(650))) - 10'sd325;
		end
		return p;
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			queue_pose(random_pose($urandom_range(9) == 0));
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed corners: origin, extremes, axes, boundary radii, field limits
		queue_pose({10'sd0, 10'sd0, 8'd0, 9'sd0});
		queue_pose({10'sd325, 10'sd0, 8'd200, 9'sd180});
		queue_pose({-10'sd325, 10'sd0, 8'd25, -9'sd180});
		queue_pose({10'sd0, 10'sd325, 8'd255, 9'sd0});
		queue_pose({10'sd0, -10'sd325, 8'd1, 9'sd255});
		queue_pose({10'sd25, 10'sd0, 8'd0, -9'sd256});
		queue_pose({10'sd26, 10'sd0, 8'd100, 9'sd90});
		queue_pose({-10'sd100, -10'sd100, 8'd50, -9'sd90});
		queue_pose({-10'sd200, 10'sd1, 8'd10, 9'sd45});
		queue_pose({-10'sd200, -10'sd1, 8'd10, 9'sd45});
		queue_pose({10'sd511, -10'sd512, 8'd128, 9'sd1});
		queue_pose({-10'sd512, 10'sd511, 8'd127, -9'sd1});
		queue_pose({10'sd175, 10'sd150, 8'd30, 9'sd10});
		queue_pose({10'sd25, 10'sd0, 8'd5, 9'sd0});
		drain();
		random_phase(300);
		// long stretch without idling on either side
		idle_free = 1'b1;
		random_phase(150);
		idle_free = 1'b0;
		write_reg(REG_ELBOW_SEL, 9'd0);
		random_phase(200);
		write_reg(REG_MAX_REACH, 9'd511);
		write_reg(REG_MIN_REACH, 9'd0);
		random_phase(150);
		write_reg(REG_MAX_REACH, 9'd100);
		write_reg(REG_MIN_REACH, 9'd200);
		random_phase(50);
		write_reg(REG_MAX_REACH, 9'd460);
		write_reg(REG_MIN_REACH, 9'd460);
		write_reg(REG_ELBOW_SEL, 9'd1);
		random_phase(50);
		write_reg(REG_MIN_REACH, 9'd10);
		write_reg(REG_MAX_REACH, 9'd300);
		random_phase(100);
		stimulus_done = 1'b1;
	end

	// final verdict and watchdog
	always @(posedge clk) begin
		if (stimulus_done) begin
			if (mismatches == 0) $display("PASS");
			else $display("FAIL");
			$finish;
		end else if (cycles > 800000) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule

// ----- filelist.f -----
src/sik_pkg.sv
src/sik_isqrt.sv
src/sik_cordic_cell.sv
src/scara_inverse_kinematics.sv
src/sik_checker.sv
dv/scara_inverse_kinematics_test.sv
